[rtl/core/b64rp_pkg.sv]
// ----------------------------------------------------------------------------
// b64rp_pkg
// Shared widths, constants and types of the binary64 round and pack unit.
// ----------------------------------------------------------------------------
package b64rp_pkg;

  localparam int SigWidth  = 64;
  localparam int ExpWidth  = 13;
  localparam int ExpFieldW = 11;
  localparam int FracBits  = 52;
  localparam int GuardBits = 3;

  localparam logic [ExpFieldW-1:0] ExpMax = 11'h7ff;
  localparam logic [2:0]           HalfRgs = 3'd4;

  typedef struct packed {
    logic                 overflow;
    logic                 sign;
    logic [ExpFieldW-1:0] exp_field;
    logic [SigWidth-1:0]  sig;
  } align_t;

endpackage

[rtl/core/b64rp_align.sv]
// ----------------------------------------------------------------------------
// b64rp_align
// Overflow detection and subnormal right shift with sticky collection.
// ----------------------------------------------------------------------------
module b64rp_align (
  input  logic [b64rp_pkg::SigWidth-1:0] significand,
  input  logic [b64rp_pkg::ExpWidth-1:0] biased_exponent,
  input  logic                           sign,
  output b64rp_pkg::align_t              aligned
);

  logic                                signed [b64rp_pkg::ExpWidth-1:0] exp_s;
  logic                                overflow;
  logic                                tiny;
  logic [b64rp_pkg::ExpWidth:0]        count;
  logic                                big;
  logic [5:0]                          shamt;
  logic [b64rp_pkg::SigWidth-1:0]      lost;
  logic [b64rp_pkg::SigWidth-1:0]      shifted;
  logic [b64rp_pkg::SigWidth-1:0]      sig_tiny;

  assign exp_s    = $signed(biased_exponent);
  assign overflow = exp_s >= $signed({2'b00, b64rp_pkg::ExpMax});
  assign tiny     = exp_s <= $signed({b64rp_pkg::ExpWidth{1'b0}});

  // shift count 1 - exp, at least one when tiny
  assign count   = 14'd1 - {biased_exponent[b64rp_pkg::ExpWidth-1], biased_exponent};
  assign big     = |count[b64rp_pkg::ExpWidth:6];
  assign shamt   = count[5:0];
  assign lost    = significand & ((64'h1 << shamt) - 64'h1);
  assign shifted = significand >> shamt;

  always_comb begin
    if (big) begin
      sig_tiny = {63'b0, |significand};
    end else begin
      sig_tiny = shifted | {63'b0, |lost};
    end
  end

  always_comb begin
    aligned.overflow = overflow;
    aligned.sign     = sign;
    if (tiny) begin
      aligned.exp_field = '0;
      aligned.sig       = sig_tiny;
    end else begin
      aligned.exp_field = biased_exponent[b64rp_pkg::ExpFieldW-1:0];
      aligned.sig       = significand;
    end
  end

endmodule

[rtl/core/b64rp_round.sv]
// ----------------------------------------------------------------------------
// b64rp_round
// Nearest-even rounding and packing into the binary64 bit pattern.
// ----------------------------------------------------------------------------
module b64rp_round (
  input  b64rp_pkg::align_t              aligned,
  output logic [b64rp_pkg::SigWidth-1:0] packed_double
);

  logic [2:0]                         rgs;
  logic                               lsb;
  logic                               inc;
  logic [b64rp_pkg::SigWidth-2:0]     body;
  logic [b64rp_pkg::SigWidth-2:0]     rounded;

  assign rgs  = aligned.sig[b64rp_pkg::GuardBits-1:0];
  assign lsb  = aligned.sig[b64rp_pkg::GuardBits];
  assign inc  = (rgs > b64rp_pkg::HalfRgs) || ((rgs == b64rp_pkg::HalfRgs) && lsb);
  assign body = {aligned.exp_field,
                 aligned.sig[b64rp_pkg::FracBits+b64rp_pkg::GuardBits-1:b64rp_pkg::GuardBits]};

  // carry out of the fraction runs into the exponent field
  assign rounded = body + {{(b64rp_pkg::SigWidth-2){1'b0}}, inc};

  always_comb begin
    if (aligned.overflow) begin
      packed_double = {aligned.sign, b64rp_pkg::ExpMax, {b64rp_pkg::FracBits{1'b0}}};
    end else begin
      packed_double = {aligned.sign, rounded};
    end
  end

endmodule

[rtl/core/binary64_round_pack_nearest_even_unit.sv]
// ----------------------------------------------------------------------------
// binary64_round_pack_nearest_even_unit
// Round to nearest even and pack a working significand into binary64.
// ----------------------------------------------------------------------------
// One item is taken every cycle while the input is not stalled; a result
// passes through the input register and then the result register.
// Between them sit the subnormal sticky shifter and the 63-bit rounding
// increment. While the output is stalled and both registers hold items, the
// input stalls.
module binary64_round_pack_nearest_even_unit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [b64rp_pkg::SigWidth-1:0] significand,
  input  logic [b64rp_pkg::ExpWidth-1:0] biased_exponent,
  input  logic                           sign,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [b64rp_pkg::SigWidth-1:0] packed_double
);

  logic                           s1_valid;
  logic [b64rp_pkg::SigWidth-1:0] s1_sig;
  logic [b64rp_pkg::ExpWidth-1:0] s1_exp;
  logic                           s1_sign;
  logic                           en1;
  logic                           en2;
  b64rp_pkg::align_t              aligned;
  logic [b64rp_pkg::SigWidth-1:0] result_next;

  assign en2      = !out_valid || !out_stall;
  assign en1      = !s1_valid || en2;
  assign in_stall = !en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en1) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en1 && in_valid) begin
      s1_sig  <= significand;
      s1_exp  <= biased_exponent;
      s1_sign <= sign;
    end
  end

  b64rp_align u_align (
    .significand     (s1_sig),
    .biased_exponent (s1_exp),
    .sign            (s1_sign),
    .aligned         (aligned)
  );

  b64rp_round u_round (
    .aligned       (aligned),
    .packed_double (result_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en2) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en2 && s1_valid) begin
      packed_double <= result_next;
    end
  end

  // full pipeline with stalled output holds off input
  a_full_stall : assert property (@(posedge clk) disable iff (rst)
    s1_valid && out_valid && out_stall |-> in_stall)
    else $error("input not stalled with full pipeline");

  // input transfer lands in the input register
  a_in_load : assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> s1_valid)
    else $error("input transfer lost");

  // an item in the input register moves on when the output frees
  a_advance : assert property (@(posedge clk) disable iff (rst)
    s1_valid && en2 |=> out_valid)
    else $error("item not advanced to result register");

  // overflow exponent gives a clean infinity
  a_overflow : assert property (@(posedge clk) disable iff (rst)
    s1_valid && en2 && aligned.overflow |=>
      packed_double[62:52] == b64rp_pkg::ExpMax && packed_double[51:0] == 52'd0)
    else $error("overflow did not produce infinity");

endmodule
